[src/scta_pkg.sv]
// Shared constants for the sigma-clipped touch averager.
`timescale 1ns / 1ps
`default_nettype none
package scta_pkg;

  localparam int SAMPLE_COUNT_DEF = 100;
  localparam int SAMPLE_BITS_DEF  = 12;
  localparam int COUNT_W          = 7;

endpackage
`default_nettype wire

[src/scta_div.sv]
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module scta_div #(
  parameter int DW = 19,
  parameter int VW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CNW = $clog2(DW + 1);

  logic           busy_r;
  logic           done_r;
  logic [CNW-1:0] cnt_r;
  logic [DW-1:0]  quo_r;
  logic [VW-1:0]  rem_r;
  logic [VW-1:0]  den_r;

  logic [VW:0]    trial;
  logic [VW:0]    diff;
  logic           ge;
  logic [VW-1:0]  rem_nxt;

  assign trial   = {rem_r, quo_r[DW-1]};
  assign diff    = trial - {1'b0, den_r};
  assign ge      = (trial >= {1'b0, den_r});
  // remainder stays below the divisor, so the top bit drops safely
  assign rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DW-2:0], ge};
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[src/sigma_clipped_touch_average_core.sv]
// A request that does not close the batch is accumulated in S_UPD, and its result is loaded into the output
// register from S_UPD, or from S_HOLD while the output is stalled; in_ready is high only in S_IDLE, so no new
// request is taken until the last result is loaded. A batch-closing request passes through S_LIM and S_VAR,
//   the one-read-per-cycle scan and the serial kept-mean divider (x, then y) before S_FIN loads its result.
// Reset clears fill count, sums and control; the sample memory is not cleared (no pass).
`timescale 1ns / 1ps
`default_nettype none
module sigma_clipped_touch_average_core #(
  parameter int SAMPLE_COUNT = scta_pkg::SAMPLE_COUNT_DEF,
  parameter int SAMPLE_BITS  = scta_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_restart,
  input  wire logic [SAMPLE_BITS-1:0]       in_sample_x,
  input  wire logic [SAMPLE_BITS-1:0]       in_sample_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_done_res,
  output logic [SAMPLE_BITS-1:0]            out_mean_x_all,
  output logic [SAMPLE_BITS-1:0]            out_mean_y_all,
  output logic [SAMPLE_BITS-1:0]            out_mean_x_kept,
  output logic [SAMPLE_BITS-1:0]            out_mean_y_kept,
  output logic [scta_pkg::COUNT_W-1:0]      out_kept_count,
  output logic                              out_none_kept
);

  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(SAMPLE_COUNT);
  localparam int CW = $clog2(SAMPLE_COUNT + 1);
  localparam int SW = SB + AW;          // sum of one axis
  localparam int QW = 2 * SB + AW;      // sum of squares
  localparam int LW = 2 * SW;           // scaled variance and squared distance
  localparam int EW = 2 * SB;           // one stored entry
  localparam int KW = scta_pkg::COUNT_W;

  // plain mean as sum * ceil(2^RK / N) >> RK, exact for every sum below 2^SW
  localparam int RK = SW + AW;
  localparam int MW = SW + 1;
  localparam int PW = SW + MW;
  localparam longint unsigned RECIP = ((64'd1 << RK) + 64'(SAMPLE_COUNT) - 64'd1) /
                                      64'(SAMPLE_COUNT);
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);

  localparam logic [SW-1:0] N_S = SW'(SAMPLE_COUNT);
  localparam logic [LW-1:0] N_L = LW'(SAMPLE_COUNT);
  localparam logic [CW-1:0] N_C = CW'(SAMPLE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_HOLD, S_LIM, S_VAR, S_SCAN, S_DIV_GO, S_DIV_WAIT, S_FIN
  } state_t;

  typedef enum logic {
    D_KEPT_X, D_KEPT_Y
  } div_sel_t;

  state_t        state_r;
  div_sel_t      div_sel_r;

  // accepted request
  logic          restart_r;
  logic [SB-1:0] x_r, y_r;
  logic [EW-1:0] sqx_r, sqy_r;

  // batch state
  logic [CW-1:0] fill_r;
  logic [SW-1:0] sum_x_r, sum_y_r;
  logic [QW-1:0] sum_sq_x_r, sum_sq_y_r;

  // limits
  logic [LW-1:0] nq_x_r, nq_y_r, ssq_x_r, ssq_y_r, lim_x_r, lim_y_r;

  // scan pipeline
  logic [CW-1:0] rd_cnt_r;
  logic          v1_r, v2_r, v3_r;
  logic [EW-1:0] rd_data_r;
  logic [SB-1:0] sx1_r, sy1_r, sx2_r, sy2_r;
  logic [SW-1:0] dx_r, dy_r;
  logic [LW-1:0] dsqx_r, dsqy_r;
  logic [SW-1:0] kx_r, ky_r;
  logic [CW-1:0] kc_r;

  // means
  logic [SB-1:0] mx_r, my_r, qx_r, qy_r;

  // output register
  logic          out_valid_r;
  logic          out_done_r;
  logic [SB-1:0] out_mxa_r, out_mya_r, out_mxk_r, out_myk_r;
  logic [KW-1:0] out_kc_r;
  logic          out_none_r;

  logic [EW-1:0] mem [SAMPLE_COUNT];

  // combinational
  logic          in_fire, out_free, out_load;
  logic [CW-1:0] fill_base, fill_inc;
  logic [SW-1:0] sum_x_base, sum_y_base;
  logic [QW-1:0] sum_sq_x_base, sum_sq_y_base;
  logic          batch_end;
  logic          wr_en;
  logic          rd_issue;
  logic [SB-1:0] sx_m, sy_m;
  logic [SW-1:0] nvx, nvy, dx, dy;
  logic          keep;
  logic [PW-1:0] mean_x_prod, mean_y_prod;
  logic          div_start, div_done;
  logic [SW-1:0] div_dividend, div_quo;
  logic [CW-1:0] div_divisor;
  logic [CW+KW-1:0] kc_wide;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_load = out_free && (((state_r == S_UPD) && !batch_end) ||
                                 (state_r == S_HOLD) || (state_r == S_FIN));

  assign fill_base     = restart_r ? '0 : fill_r;
  assign sum_x_base    = restart_r ? '0 : sum_x_r;
  assign sum_y_base    = restart_r ? '0 : sum_y_r;
  assign sum_sq_x_base = restart_r ? '0 : sum_sq_x_r;
  assign sum_sq_y_base = restart_r ? '0 : sum_sq_y_r;
  assign fill_inc      = fill_base + 1'b1;
  assign batch_end     = (fill_inc == N_C);

  assign wr_en    = (state_r == S_UPD);
  assign rd_issue = (state_r == S_SCAN) && (rd_cnt_r != N_C);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_base[AW-1:0]] <= {y_r, x_r};
    end
    rd_data_r <= mem[rd_cnt_r[AW-1:0]];
  end

  // distance from the mean, scaled by the batch size
  assign sx_m = rd_data_r[SB-1:0];
  assign sy_m = rd_data_r[EW-1:SB];
  assign nvx  = N_S * SW'(sx_m);
  assign nvy  = N_S * SW'(sy_m);
  assign dx   = (nvx >= sum_x_r) ? (nvx - sum_x_r) : (sum_x_r - nvx);
  assign dy   = (nvy >= sum_y_r) ? (nvy - sum_y_r) : (sum_y_r - nvy);
  assign keep = (dsqx_r < lim_x_r) && (dsqy_r < lim_y_r);

  assign mean_x_prod = PW'(sum_x_r) * PW'(RECIP_M);
  assign mean_y_prod = PW'(sum_y_r) * PW'(RECIP_M);

  always_comb begin
    div_dividend = kx_r;
    case (div_sel_r)
      D_KEPT_X: begin
        div_dividend = kx_r;
      end
      D_KEPT_Y: begin
        div_dividend = ky_r;
      end
      default: begin
        div_dividend = kx_r;
      end
    endcase
  end

  assign div_divisor = kc_r;
  assign div_start   = (state_r == S_DIV_GO);
  assign kc_wide     = {{KW{1'b0}}, kc_r};

  scta_div #(
    .DW(SW),
    .VW(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_sel_r   <= D_KEPT_X;
      fill_r      <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_sq_x_r  <= '0;
      sum_sq_y_r  <= '0;
      rd_cnt_r    <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      // scan pipeline valids
      v1_r <= rd_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      if (v1_r) begin
        dx_r  <= dx;
        dy_r  <= dy;
        sx1_r <= sx_m;
        sy1_r <= sy_m;
      end
      if (v2_r) begin
        dsqx_r <= LW'(dx_r) * LW'(dx_r);
        dsqy_r <= LW'(dy_r) * LW'(dy_r);
        sx2_r  <= sx1_r;
        sy2_r  <= sy1_r;
      end
      if (v3_r && keep) begin
        kx_r <= kx_r + SW'(sx2_r);
        ky_r <= ky_r + SW'(sy2_r);
        kc_r <= kc_r + 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            restart_r <= in_restart;
            x_r       <= in_sample_x;
            y_r       <= in_sample_y;
            sqx_r     <= EW'(in_sample_x) * EW'(in_sample_x);
            sqy_r     <= EW'(in_sample_y) * EW'(in_sample_y);
            state_r   <= S_UPD;
          end
        end
        S_UPD: begin
          fill_r     <= fill_inc;
          sum_x_r    <= sum_x_base + SW'(x_r);
          sum_y_r    <= sum_y_base + SW'(y_r);
          sum_sq_x_r <= sum_sq_x_base + QW'(sqx_r);
          sum_sq_y_r <= sum_sq_y_base + QW'(sqy_r);
          if (batch_end) begin
            state_r <= S_LIM;
          end else if (out_free) begin
            out_valid_r <= 1'b1;
            out_done_r  <= 1'b0;
            out_mxa_r   <= '0;
            out_mya_r   <= '0;
            out_mxk_r   <= '0;
            out_myk_r   <= '0;
            out_kc_r    <= '0;
            out_none_r  <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_done_r  <= 1'b0;
            out_mxa_r   <= '0;
            out_mya_r   <= '0;
            out_mxk_r   <= '0;
            out_myk_r   <= '0;
            out_kc_r    <= '0;
            out_none_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        S_LIM: begin
          nq_x_r  <= N_L * LW'(sum_sq_x_r);
          nq_y_r  <= N_L * LW'(sum_sq_y_r);
          ssq_x_r <= LW'(sum_x_r) * LW'(sum_x_r);
          ssq_y_r <= LW'(sum_y_r) * LW'(sum_y_r);
          mx_r    <= mean_x_prod[RK +: SB];
          my_r    <= mean_y_prod[RK +: SB];
          state_r <= S_VAR;
        end
        S_VAR: begin
          // never negative: N*Q >= S^2
          lim_x_r  <= nq_x_r - ssq_x_r;
          lim_y_r  <= nq_y_r - ssq_y_r;
          rd_cnt_r <= '0;
          kx_r     <= '0;
          ky_r     <= '0;
          kc_r     <= '0;
          state_r  <= S_SCAN;
        end
        S_SCAN: begin
          if (!rd_issue && !v1_r && !v2_r && !v3_r) begin
            div_sel_r <= D_KEPT_X;
            state_r   <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            case (div_sel_r)
              D_KEPT_X: begin
                qx_r      <= div_quo[SB-1:0];
                div_sel_r <= D_KEPT_Y;
                state_r   <= S_DIV_GO;
              end
              D_KEPT_Y: begin
                qy_r    <= div_quo[SB-1:0];
                state_r <= S_FIN;
              end
              default: begin
                state_r <= S_FIN;
              end
            endcase
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_done_r  <= 1'b1;
            out_mxa_r   <= mx_r;
            out_mya_r   <= my_r;
            // no sample kept: repeat the plain means
            out_mxk_r   <= (kc_r == '0) ? mx_r : qx_r;
            out_myk_r   <= (kc_r == '0) ? my_r : qy_r;
            out_kc_r    <= kc_wide[KW-1:0];
            out_none_r  <= (kc_r == '0);
            fill_r      <= '0;
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            sum_sq_x_r  <= '0;
            sum_sq_y_r  <= '0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_done_res    = out_done_r;
  assign out_mean_x_all  = out_mxa_r;
  assign out_mean_y_all  = out_mya_r;
  assign out_mean_x_kept = out_mxk_r;
  assign out_mean_y_kept = out_myk_r;
  assign out_kept_count  = out_kc_r;
  assign out_none_kept   = out_none_r;

endmodule
`default_nettype wire

[tb/sigma_clipped_touch_average_core_tb.sv]
// Testbench for the sigma-clipped touch averager: directed and random batches, scoreboard check.
`timescale 1ns / 1ps
module sigma_clipped_touch_average_core_tb;

  localparam int N_SAMPLES    = scta_pkg::SAMPLE_COUNT_DEF;
  localparam int SB           = scta_pkg::SAMPLE_BITS_DEF;
  localparam int CW           = scta_pkg::COUNT_W;
  localparam int MAX_VALUE    = (1 << SB) - 1;
  localparam logic [SB-1:0] FULL_SCALE = SB'(MAX_VALUE);
  localparam int RANDOM_ITEMS = 560;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    logic          done_res;
    logic [SB-1:0] mean_x_all;
    logic [SB-1:0] mean_y_all;
    logic [SB-1:0] mean_x_kept;
    logic [SB-1:0] mean_y_kept;
    logic [CW-1:0] kept_count;
    logic          none_kept;
  } touch_result_t;

  typedef enum int {
    MODE_UNIFORM, MODE_CLUSTER, MODE_TWO_LEVEL, MODE_OUTLIERS
  } value_mode_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_restart = 1'b0;
  logic [SB-1:0] in_sample_x = '0;
  logic [SB-1:0] in_sample_y = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic          out_done_res;
  logic [SB-1:0] out_mean_x_all;
  logic [SB-1:0] out_mean_y_all;
  logic [SB-1:0] out_mean_x_kept;
  logic [SB-1:0] out_mean_y_kept;
  logic [CW-1:0] out_kept_count;
  logic          out_none_kept;

  // predictor state: the current batch and its running sums
  logic [SB-1:0]   batch_x [N_SAMPLES];
  logic [SB-1:0]   batch_y [N_SAMPLES];
  int              batch_fill = 0;
  longint unsigned sum_x = 0, sum_y = 0, sum_sq_x = 0, sum_sq_y = 0;

  touch_result_t pending_results[$];

  int  mismatch_count = 0;
  int  samples_sent = 0;
  int  results_seen = 0;
  int  batches_closed = 0;
  int  empty_batches = 0;
  int  cycle_count = 0;
  int  rx_wait = 0;
  bit  tx_no_idle = 1'b0;
  bit  rx_no_stall = 1'b0;

  sigma_clipped_touch_average_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_done_res   (out_done_res),
    .out_mean_x_all (out_mean_x_all),
    .out_mean_y_all (out_mean_y_all),
    .out_mean_x_kept(out_mean_x_kept),
    .out_mean_y_kept(out_mean_y_kept),
    .out_kept_count (out_kept_count),
    .out_none_kept  (out_none_kept)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_batch_sums();
    batch_fill = 0;
    sum_x      = 0;
    sum_y      = 0;
    sum_sq_x   = 0;
    sum_sq_y   = 0;
  endfunction

  // |N*v - S| strictly below the scaled deviation, all in exact integers
  function automatic bit in_one_sigma(longint unsigned v, longint unsigned s,
                                      longint unsigned lim);
    longint unsigned nv, d;
    nv = v * 64'(N_SAMPLES);
    d  = (nv >= s) ? nv - s : s - nv;
    return (d * d) < lim;
  endfunction

  function automatic touch_result_t predict_touch_result(bit restart, logic [SB-1:0] x,
                                                         logic [SB-1:0] y);
    touch_result_t   r;
    longint unsigned xv, yv, n, lim_x, lim_y, mx, my, kx, ky, kc;
    r  = '{default: '0};
    xv = 64'(x);
    yv = 64'(y);
    n  = 64'(N_SAMPLES);
    if (restart)
      clear_batch_sums();
    if (batch_fill >= N_SAMPLES)
      batch_fill = 0;
    batch_x[batch_fill] = x;
    batch_y[batch_fill] = y;
    batch_fill++;
    sum_x    += xv;
    sum_y    += yv;
    sum_sq_x += xv * xv;
    sum_sq_y += yv * yv;
    if (batch_fill >= N_SAMPLES) begin
      lim_x = n * sum_sq_x - sum_x * sum_x;
      lim_y = n * sum_sq_y - sum_y * sum_y;
      mx = sum_x / n;
      my = sum_y / n;
      kx = 0;
      ky = 0;
      kc = 0;
      for (int i = 0; i < N_SAMPLES; i++) begin
        if (in_one_sigma(64'(batch_x[i]), sum_x, lim_x) &&
            in_one_sigma(64'(batch_y[i]), sum_y, lim_y)) begin
          kx += 64'(batch_x[i]);
          ky += 64'(batch_y[i]);
          kc++;
        end
      end
      r.done_res   = 1'b1;
      r.mean_x_all = mx[SB-1:0];
      r.mean_y_all = my[SB-1:0];
      r.kept_count = kc[CW-1:0];
      if (kc != 0) begin
        kx = kx / kc;
        ky = ky / kc;
        r.mean_x_kept = kx[SB-1:0];
        r.mean_y_kept = ky[SB-1:0];
        r.none_kept   = 1'b0;
      end else begin
        // nothing inside one sigma: kept means fall back to the plain means
        r.mean_x_kept = mx[SB-1:0];
        r.mean_y_kept = my[SB-1:0];
        r.none_kept   = 1'b1;
      end
      clear_batch_sums();
    end
    return r;
  endfunction

  task send_sample(input bit restart, input logic [SB-1:0] x, input logic [SB-1:0] y);
    int gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_restart  <= restart;
    in_sample_x <= x;
    in_sample_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_touch_result(restart, x, y));
    samples_sent++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: expected %0d, got %0d", results_seen, name,
                                want, got));
  endtask

  // result sink: random backpressure plus scoreboard compare
  always @(posedge clk) begin
    touch_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        compare_field("done_res", 32'(want.done_res), 32'(out_done_res));
        compare_field("mean_x_all", 32'(want.mean_x_all), 32'(out_mean_x_all));
        compare_field("mean_y_all", 32'(want.mean_y_all), 32'(out_mean_y_all));
        compare_field("mean_x_kept", 32'(want.mean_x_kept), 32'(out_mean_x_kept));
        compare_field("mean_y_kept", 32'(want.mean_y_kept), 32'(out_mean_y_kept));
        compare_field("kept_count", 32'(want.kept_count), 32'(out_kept_count));
        compare_field("none_kept", 32'(want.none_kept), 32'(out_none_kept));
        if (want.done_res) begin
          batches_closed++;
          if (want.none_kept)
            empty_batches++;
        end
      end
      results_seen++;
      rx_wait = rx_no_stall ? 0 : $urandom_range(0, 14);
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_ready <= (rx_wait == 0);
  end

  function automatic logic [SB-1:0] clamp_value(int v);
    if (v < 0)
      return '0;
    if (v > MAX_VALUE)
      return FULL_SCALE;
    return v[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] pick_value(value_mode_t mode, int center, int spread);
    case (mode)
      MODE_UNIFORM: return SB'($urandom_range(0, MAX_VALUE));
      MODE_CLUSTER: return clamp_value(center + int'($urandom_range(0, 2 * spread)) - spread);
      MODE_TWO_LEVEL:
        return $urandom_range(0, 1) ? clamp_value(center) : clamp_value(center + spread);
      default: begin
        // tight cluster with rare outliers
        if ($urandom_range(0, 15) == 0)
          return SB'($urandom_range(0, MAX_VALUE));
        return clamp_value(center + int'($urandom_range(0, spread / 8)) - spread / 16);
      end
    endcase
  endfunction

  // short runs broken by restarts; none of these close a batch
  task test_partial_and_restart();
    send_sample(1'b1, '0, FULL_SCALE);
    send_sample(1'b0, FULL_SCALE, '0);
    send_sample(1'b0, 12'h555, 12'haaa);
    send_sample(1'b1, 12'haaa, 12'h555);
    send_sample(1'b0, FULL_SCALE, FULL_SCALE);
    send_sample(1'b0, '0, '0);
    send_sample(1'b1, 12'h800, 12'h7ff);
    send_sample(1'b1, 12'h001, 12'hffe);
    send_sample(1'b0, 12'h7ff, 12'h800);
    send_sample(1'b1, '0, '0);
  endtask

  // zero spread on both axes: nothing can be kept
  task test_flat_batch();
    for (int i = 0; i < N_SAMPLES; i++)
      send_sample(i == 0, FULL_SCALE, '0);
  endtask

  // half at each extreme: every sample sits exactly at one sigma and fails the strict test
  task test_balanced_batch();
    for (int i = 0; i < N_SAMPLES; i++)
      send_sample(1'b0, (i % 2) ? FULL_SCALE : '0, (i % 2) ? '0 : FULL_SCALE);
  endtask

  // tight cluster with one far outlier, closed without restart; next batch follows on
  task test_outlier_batch();
    int spot;
    spot = $urandom_range(0, N_SAMPLES - 1);
    for (int i = 0; i < N_SAMPLES; i++) begin
      if (i == spot)
        send_sample(1'b0, FULL_SCALE, '0);
      else
        send_sample(1'b0, clamp_value(2000 + int'($urandom_range(0, 8)) - 4),
                    clamp_value(1000 + int'($urandom_range(0, 8)) - 4));
    end
  endtask

  task test_random_batches();
    value_mode_t mode;
    int cx, cy, spread, len, sent;
    bit lead_restart;
    sent = 0;
    lead_restart = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      mode   = value_mode_t'($urandom_range(0, 3));
      cx     = $urandom_range(0, MAX_VALUE);
      cy     = $urandom_range(0, MAX_VALUE);
      spread = $urandom_range(0, 400);
      // mostly full batches; now and then a batch cut short by a restart
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, N_SAMPLES - 1) : N_SAMPLES;
      tx_no_idle  = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++)
        send_sample(i == 0 && lead_restart, pick_value(mode, cx, spread),
                    pick_value(mode, cy, spread));
      sent += len;
      lead_restart = (len != N_SAMPLES) || ($urandom_range(0, 3) == 0);
    end
    tx_no_idle  = 1'b0;
    rx_no_stall = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_partial_and_restart();
    test_flat_batch();
    test_balanced_batch();
    test_outlier_batch();
    test_random_batches();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d samples, checked %0d results over %0d closed batches",
             samples_sent, results_seen, batches_closed);
    $display("%0d of those batches had no sample inside one sigma", empty_batches);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
